### design/tdlt_pkg.sv
package tdlt_pkg;

	localparam int NUM_STATES_DEF = 32768;

	localparam logic [15:0] LEARN_RATE_RST  = 16'd6554;
	localparam logic [15:0] DISCOUNT_RST    = 16'd64251;
	localparam logic [15:0] TRACE_DECAY_RST = 16'd52429;

	localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
	localparam logic [1:0] REG_DISCOUNT    = 2'd1;
	localparam logic [1:0] REG_TRACE_DECAY = 2'd2;

	localparam logic [1:0] FN_STEP = 2'd0;
	localparam logic [1:0] FN_END  = 2'd1;
	localparam logic [1:0] FN_LOAD = 2'd2;

	localparam logic [23:0] TRACE_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic               mark;
		logic [23:0]        trace;
		logic signed [31:0] value;
	} entry_t;

	function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] r;
		m = p[63] ? 64'(-p) : 64'(p);
		r = (m + 64'd32768) >> 16;
		return p[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic over32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

endpackage

### design/td_lambda_trace_update.sv
// Step item: index reduction, then one read-modify-write of the state memory
// per listed state; end-of-episode item: index reduction, then one clearing
// read-modify-write per listed state; load: one write; any other item: report only.
// One item in work at a time; the next item is taken in the cycle after the result
// enters the output register, which holds it while m_tready is low.
// After reset a clearing pass zeroes the state memory before the first item is taken.
module td_lambda_trace_update #(
	parameter int NUM_STATES = tdlt_pkg::NUM_STATES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // from_state[14:0], to_state[29:15], value_in[61:30]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // state_value[31:0], td_error[63:32],
	                              // visited_count[79:64], saturated[80]
	input  logic        wr_en,
	input  logic [1:0]  wr_addr,
	input  logic [15:0] wr_data
);

	localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int LW = $clog2(NUM_STATES + 1);
	localparam int RSH = 15 + AW;
	localparam logic [47:0] RMUL =
		48'(((64'd1 << RSH) + 64'(NUM_STATES) - 64'd1) / 64'(NUM_STATES));

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MOD, ST_DISP, ST_GV, ST_DELTA, ST_RDT, ST_ADDT,
		ST_COEF, ST_WRL, ST_WRE, ST_WMUL, ST_WWR, ST_LDWR, ST_REPRD, ST_REP
	} state_t;

	state_t state_q;
	logic [15:0] alpha_q, gamma_q, lambda_q;
	logic [1:0]  func_q;
	logic [14:0] f_q, t_q;
	logic [14:0] fq_q, tq_q;
	logic signed [31:0] val_q;
	logic        k_q;
	logic [LW-1:0] len_q, i_q;
	logic [AW-1:0] s_q, clr_q;
	logic signed [48:0] gp_q, adp_q;
	logic [31:0] glp_q;
	logic signed [31:0] delta_q;
	logic signed [32:0] ad_q;
	logic [15:0] gl_q;
	logic signed [57:0] mp_q;
	logic [39:0] tp_q;
	tdlt_pkg::entry_t e_q;
	logic sat_q;
	logic out_valid_q;
	logic [87:0] out_q;

	tdlt_pkg::entry_t em [NUM_STATES];
	logic [AW-1:0]    lm [NUM_STATES];
	tdlt_pkg::entry_t em_rd, em_wd;
	logic [AW-1:0]    em_ra, em_wa, lm_rd, lm_ra, lm_wa, lm_wd;
	logic             em_we, lm_we;

	logic [AW-1:0] fi, ti;
	logic len_lt, add_new, last;
	logic signed [63:0] gv, dsum, inc, vsum;
	logic [24:0] tr_sum;
	logic tr_sat;
	logic [23:0] tr_new, nt;
	logic [39:0] tp_rnd;

	assign fi = AW'(f_q);
	assign ti = AW'(t_q);
	assign len_lt = len_q < LW'(NUM_STATES);
	assign add_new = !em_rd.mark && len_lt;
	assign last = (i_q + LW'(1)) == len_q;

	assign gv = tdlt_pkg::rnd16(64'(gp_q));
	assign dsum = 64'(val_q) + gv - 64'($signed(em_rd.value));
	assign tr_sum = {1'b0, em_rd.trace} + 25'h10000;
	assign tr_sat = tr_sum[24];
	assign tr_new = tr_sat ? tdlt_pkg::TRACE_MAX : tr_sum[23:0];

	assign inc = tdlt_pkg::rnd16(64'(mp_q));
	assign vsum = 64'($signed(e_q.value)) + inc;
	assign tp_rnd = (tp_q + 40'd32768) >> 16;
	assign nt = tp_rnd[23:0];

	always_comb begin
		em_we = 1'b0;
		em_wa = fi;
		em_wd = em_rd;
		em_ra = fi;
		lm_we = 1'b0;
		lm_wa = len_q[AW-1:0];
		lm_wd = fi;
		lm_ra = i_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				em_we = 1'b1;
				em_wa = clr_q;
				em_wd = '0;
			end
			ST_DISP: begin
				em_ra = (func_q == tdlt_pkg::FN_STEP) ? ti : fi;
			end
			ST_DELTA: begin
				em_we = 1'b1;
				em_wd.mark = 1'b1;
				em_wd.trace = tr_new;
				lm_we = add_new;
			end
			ST_RDT: begin
				em_ra = ti;
			end
			ST_ADDT: begin
				em_we = add_new;
				em_wa = ti;
				em_wd.mark = 1'b1;
				lm_we = add_new;
				lm_wd = ti;
			end
			ST_WRE: begin
				em_ra = lm_rd;
			end
			ST_WMUL: begin
				em_we = (func_q == tdlt_pkg::FN_END);
				em_wa = s_q;
				em_wd.mark = 1'b0;
				em_wd.trace = '0;
			end
			ST_WWR: begin
				em_we = 1'b1;
				em_wa = s_q;
				em_wd.mark = e_q.mark;
				em_wd.trace = nt;
				em_wd.value = tdlt_pkg::sat32(vsum);
			end
			ST_LDWR: begin
				em_we = 1'b1;
				em_wd.value = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (em_we) begin
			em[em_wa] <= em_wd;
		end
		em_rd <= em[em_ra];
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			lm[lm_wa] <= lm_wd;
		end
		lm_rd <= lm[lm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= tdlt_pkg::LEARN_RATE_RST;
			gamma_q  <= tdlt_pkg::DISCOUNT_RST;
			lambda_q <= tdlt_pkg::TRACE_DECAY_RST;
		end else if (wr_en) begin
			case (wr_addr)
				tdlt_pkg::REG_LEARN_RATE:  alpha_q  <= wr_data;
				tdlt_pkg::REG_DISCOUNT:    gamma_q  <= wr_data;
				tdlt_pkg::REG_TRACE_DECAY: lambda_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			len_q       <= '0;
			i_q         <= '0;
			k_q         <= 1'b0;
			func_q      <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_REP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_STATES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						func_q  <= s_tuser;
						f_q     <= s_tdata[14:0];
						t_q     <= s_tdata[29:15];
						val_q   <= s_tdata[61:30];
						k_q     <= 1'b1;
						sat_q   <= 1'b0;
						delta_q <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (k_q) begin
						fq_q <= 15'((48'(f_q) * RMUL) >> RSH);
						tq_q <= 15'((48'(t_q) * RMUL) >> RSH);
						k_q  <= 1'b0;
					end else begin
						f_q     <= f_q - 15'(48'(fq_q) * 48'(NUM_STATES));
						t_q     <= t_q - 15'(48'(tq_q) * 48'(NUM_STATES));
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					i_q <= '0;
					case (func_q)
						tdlt_pkg::FN_STEP: state_q <= ST_GV;
						tdlt_pkg::FN_END:  state_q <= (len_q == '0) ? ST_REPRD : ST_WRL;
						tdlt_pkg::FN_LOAD: state_q <= ST_LDWR;
						default:           state_q <= ST_REPRD;
					endcase
				end
				ST_GV: begin
					gp_q    <= $signed({1'b0, gamma_q}) * $signed(em_rd.value);
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					delta_q <= tdlt_pkg::sat32(dsum);
					sat_q   <= tdlt_pkg::over32(dsum) | tr_sat;
					if (add_new) begin
						len_q <= len_q + LW'(1);
					end
					state_q <= ST_RDT;
				end
				ST_RDT: begin
					state_q <= ST_ADDT;
				end
				ST_ADDT: begin
					if (add_new) begin
						len_q <= len_q + LW'(1);
					end
					adp_q   <= $signed({1'b0, alpha_q}) * delta_q;
					glp_q   <= gamma_q * lambda_q;
					state_q <= ST_COEF;
				end
				ST_COEF: begin
					ad_q    <= 33'(tdlt_pkg::rnd16(64'(adp_q)));
					gl_q    <= 16'(tdlt_pkg::rnd16(64'(glp_q)));
					state_q <= ST_WRL;
				end
				ST_WRL: begin
					state_q <= ST_WRE;
				end
				ST_WRE: begin
					s_q     <= lm_rd;
					state_q <= ST_WMUL;
				end
				ST_WMUL: begin
					e_q  <= em_rd;
					mp_q <= ad_q * $signed({1'b0, em_rd.trace});
					tp_q <= em_rd.trace * gl_q;
					if (func_q == tdlt_pkg::FN_END) begin
						if (last) begin
							len_q   <= '0;
							state_q <= ST_REPRD;
						end else begin
							i_q     <= i_q + LW'(1);
							state_q <= ST_WRL;
						end
					end else begin
						state_q <= ST_WWR;
					end
				end
				ST_WWR: begin
					sat_q <= sat_q | tdlt_pkg::over32(vsum);
					if (last) begin
						state_q <= ST_REPRD;
					end else begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_WRL;
					end
				end
				ST_LDWR: begin
					state_q <= ST_REPRD;
				end
				ST_REPRD: begin
					state_q <= ST_REP;
				end
				ST_REP: begin
					if (!out_valid_q || m_tready) begin
						out_q[31:0]  <= em_rd.value;
						out_q[63:32] <= (func_q == tdlt_pkg::FN_STEP) ? delta_q : '0;
						out_q[79:64] <= 16'(len_q);
						out_q[80]    <= (func_q == tdlt_pkg::FN_STEP) & sat_q;
						out_q[87:81] <= '0;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### dv/td_lambda_trace_update_tb.sv
module td_lambda_trace_update_tb;

	localparam int STATE_COUNT = 32768;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic [31:0] state_value;
		logic [31:0] td_error;
		logic [15:0] visited_count;
		logic        saturated;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        wr_en;
	logic [1:0]  wr_addr;
	logic [15:0] wr_data;

	td_lambda_trace_update i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// learner state mirror
	logic [15:0] alpha, gamma, lambda;
	int          values [STATE_COUNT];
	logic [23:0] traces [STATE_COUNT];
	bit          marks  [STATE_COUNT];
	int          visit_q[$];

	outcome_t pending_q[$];
	int       errors;
	bit       quiet;
	bit       hold_req;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint round_q16(input longint p);
		longint m;
		m = (p < 0) ? -p : p;
		m = (m + 32768) >> 16;
		return (p < 0) ? -m : m;
	endfunction

	function automatic int clamp32(input longint x, inout bit flag);
		if (x > 64'sd2147483647) begin
			flag = 1;
			return 32'h7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			flag = 1;
			return 32'h80000000;
		end
		return int'(x);
	endfunction

	task automatic mark_visit(input int s);
		if (!marks[s]) begin
			marks[s] = 1;
			visit_q.push_back(s);
		end
	endtask

	task automatic learner_apply(input logic [1:0] fn, input logic [14:0] f,
			input logic [14:0] t, input logic [31:0] raw);
		longint   gv, ad, gl, inc;
		bit       sat;
		int       delta;
		int       s;
		outcome_t r;
		sat = 0;
		delta = 0;
		case (fn)
			tdlt_pkg::FN_STEP: begin
				gv = round_q16(longint'(gamma) * longint'(values[t]));
				delta = clamp32(longint'($signed(raw)) + gv - longint'(values[f]), sat);
				if (int'(traces[f]) + 65536 > int'(tdlt_pkg::TRACE_MAX)) begin
					traces[f] = tdlt_pkg::TRACE_MAX;
					sat = 1;
				end else begin
					traces[f] = traces[f] + 24'd65536;
				end
				mark_visit(int'(f));
				mark_visit(int'(t));
				ad = round_q16(longint'(alpha) * longint'(delta));
				gl = round_q16(longint'(gamma) * longint'(lambda));
				foreach (visit_q[i]) begin
					s = visit_q[i];
					inc = round_q16(ad * longint'(traces[s]));
					values[s] = clamp32(longint'(values[s]) + inc, sat);
					traces[s] = 24'(round_q16(longint'(traces[s]) * gl));
				end
			end
			tdlt_pkg::FN_END: begin
				foreach (visit_q[i]) begin
					traces[visit_q[i]] = '0;
					marks[visit_q[i]] = 0;
				end
				visit_q.delete();
			end
			tdlt_pkg::FN_LOAD: begin
				values[f] = raw;
			end
			default: ;
		endcase
		r.state_value = values[f];
		r.td_error = delta;
		r.visited_count = 16'(visit_q.size());
		r.saturated = sat;
		pending_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[31:0], '0);
			end else begin
				w = pending_q.pop_front();
				if (m_tdata[31:0] !== w.state_value)
					report_mismatch("state_value", m_tdata[31:0], w.state_value);
				if (m_tdata[63:32] !== w.td_error)
					report_mismatch("td_error", m_tdata[63:32], w.td_error);
				if (m_tdata[79:64] !== w.visited_count)
					report_mismatch("visited_count", 32'(m_tdata[79:64]),
						32'(w.visited_count));
				if (m_tdata[80] !== w.saturated)
					report_mismatch("saturated", 32'(m_tdata[80]), 32'(w.saturated));
			end
		end
	end

	// receiver: random stalls, one long hold on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++)
					@(negedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [1:0] fn, input logic [14:0] f,
			input logic [14:0] t, input logic [31:0] val);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, val, t, f};
		do @(posedge clk); while (!s_tready);
		learner_apply(fn, f, t, val);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		drain();
		@(negedge clk);
		wr_en   <= 1'b1;
		wr_addr <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			tdlt_pkg::REG_LEARN_RATE:  alpha = data;
			tdlt_pkg::REG_DISCOUNT:    gamma = data;
			tdlt_pkg::REG_TRACE_DECAY: lambda = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_learner(input logic [15:0] a, input logic [15:0] g,
			input logic [15:0] l);
		write_reg(tdlt_pkg::REG_LEARN_RATE, a);
		write_reg(tdlt_pkg::REG_DISCOUNT, g);
		write_reg(tdlt_pkg::REG_TRACE_DECAY, l);
	endtask

	function automatic logic [31:0] pick_reward();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return 32'($signed($urandom_range(0, 1310720)) - 655360);
		endcase
	endfunction

	task automatic test_basic_ops;
		send_item(tdlt_pkg::FN_STEP, 15'd0, 15'd1, 32'h0001_0000);
		send_item(tdlt_pkg::FN_STEP, 15'd1, 15'd1, 32'h0000_8000);
		send_item(tdlt_pkg::FN_STEP, 15'h7FFF, 15'd0, 32'hFFFF_0000);
		send_item(tdlt_pkg::FN_LOAD, 15'd2, 15'h7FFF, 32'h7FFF_FFFF);
		send_item(tdlt_pkg::FN_LOAD, 15'd3, 15'd0, 32'h8000_0000);
		send_item(2'd3, 15'd2, 15'h7FFF, 32'hFFFF_FFFF);
		send_item(tdlt_pkg::FN_STEP, 15'd3, 15'd2, 32'h7FFF_FFFF);
		send_item(tdlt_pkg::FN_STEP, 15'd2, 15'd3, 32'h8000_0000);
		send_item(tdlt_pkg::FN_STEP, 15'd2, 15'd2, 32'h0000_0000);
		send_item(tdlt_pkg::FN_END, 15'd2, 15'd0, 32'h1234_5678);
		send_item(tdlt_pkg::FN_END, 15'h7FFF, 15'h7FFF, 32'h0);
		send_item(tdlt_pkg::FN_LOAD, 15'h5555, 15'h2AAA, 32'h5555_5555);
		send_item(tdlt_pkg::FN_STEP, 15'h2AAA, 15'h5555, 32'hAAAA_AAAA);
		send_item(tdlt_pkg::FN_STEP, 15'h5555, 15'h2AAA, 32'h0);
		send_item(2'd3, 15'h5555, 15'h0, 32'h0);
		send_item(tdlt_pkg::FN_END, 15'h5555, 15'h0, 32'h0);
	endtask

	task automatic test_register_extremes;
		logic [15:0] lim [2];
		lim[0] = 16'h0000;
		lim[1] = 16'hFFFF;
		for (int k = 0; k < 8; k++) begin
			set_learner(lim[k[0]], lim[k[1]], lim[k[2]]);
			send_item(tdlt_pkg::FN_LOAD, 15'd10, 15'd0, 32'h0004_0000);
			send_item(tdlt_pkg::FN_STEP, 15'd11, 15'd10, 32'h0001_0000);
			send_item(tdlt_pkg::FN_STEP, 15'd10, 15'd11, 32'hFFFE_0000);
			send_item(tdlt_pkg::FN_END, 15'd10, 15'd0, 32'h0);
		end
		set_learner(tdlt_pkg::LEARN_RATE_RST, tdlt_pkg::DISCOUNT_RST,
			tdlt_pkg::TRACE_DECAY_RST);
	endtask

	task automatic test_trace_saturation;
		set_learner(16'd0, 16'hFFFF, 16'hFFFF);
		for (int k = 0; k < 262; k++)
			send_item(tdlt_pkg::FN_STEP, 15'd77, 15'd77, 32'h0);
		send_item(tdlt_pkg::FN_END, 15'd77, 15'd0, 32'h0);
		set_learner(tdlt_pkg::LEARN_RATE_RST, tdlt_pkg::DISCOUNT_RST,
			tdlt_pkg::TRACE_DECAY_RST);
	endtask

	task automatic test_backpressure;
		drain();
		hold_req = 1;
		for (int k = 0; k < 40; k++)
			send_item(k % 9 == 8 ? tdlt_pkg::FN_END : tdlt_pkg::FN_STEP,
				15'(100 + k % 5), 15'(101 + k % 7), pick_reward());
		send_item(tdlt_pkg::FN_END, 15'd100, 15'd0, 32'h0);
	endtask

	task automatic run_episode;
		int          pool, steps;
		logic [14:0] base;
		logic [14:0] f, t;
		base  = 15'($urandom_range(0, STATE_COUNT - 1));
		pool  = $urandom_range(1, 16);
		steps = $urandom_range(1, 30);
		for (int k = 0; k < steps; k++) begin
			f = base + 15'($urandom_range(0, pool - 1));
			t = base + 15'($urandom_range(0, pool - 1));
			if ($urandom_range(0, 9) == 0)
				t = 15'($urandom);
			case ($urandom_range(0, 14))
				0: send_item(2'd3, 15'($urandom), 15'($urandom), $urandom);
				1: send_item(tdlt_pkg::FN_LOAD, f, 15'($urandom), pick_reward());
				default: send_item(tdlt_pkg::FN_STEP, f, t, pick_reward());
			endcase
		end
		if ($urandom_range(0, 7) != 0)
			send_item(tdlt_pkg::FN_END, base, 15'($urandom), $urandom);
	endtask

	task automatic test_random_episodes;
		logic [15:0] regs [3];
		for (int ep = 0; ep < 35; ep++) begin
			if (ep % 8 == 7) begin
				foreach (regs[i])
					case ($urandom_range(0, 3))
						0: regs[i] = 16'h0000;
						1: regs[i] = 16'hFFFF;
						default: regs[i] = 16'($urandom);
					endcase
				set_learner(regs[0], regs[1], regs[2]);
			end
			run_episode();
			if (visit_q.size() > 48)
				send_item(tdlt_pkg::FN_END, 15'd0, 15'd0, 32'h0);
		end
	endtask

	task automatic test_no_gaps;
		quiet = 1;
		for (int ep = 0; ep < 8; ep++)
			run_episode();
		send_item(tdlt_pkg::FN_END, 15'd0, 15'd0, 32'h0);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		errors   = 0;
		quiet    = 0;
		hold_req = 0;
		alpha    = tdlt_pkg::LEARN_RATE_RST;
		gamma    = tdlt_pkg::DISCOUNT_RST;
		lambda   = tdlt_pkg::TRACE_DECAY_RST;
		foreach (values[i]) begin
			values[i] = 0;
			traces[i] = '0;
			marks[i]  = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_register_extremes();
		test_trace_saturation();
		test_backpressure();
		test_random_episodes();
		test_no_gaps();
		drain();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/tdlt_pkg.sv
design/td_lambda_trace_update.sv
dv/td_lambda_trace_update_tb.sv
